// File: rtl/ows_pkg.sv
// Shared types, codes and constants for the 1-Wire search ROM decision engine.
// Used by ows_engine, ows_out_fifo and onewire_rom_search_top; no dependencies.
package ows_pkg;

    // ROM size, the bit-position limits that follow from it and the result queue sizes
    localparam int ROM_BYTES     = 8;
    localparam int ROM_BITS      = ROM_BYTES * 8;
    localparam int POS_W         = 7;
    localparam int FAMILY_LIMIT  = 9;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW       = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] SEARCH_CMD_RESET = 8'hF0;

    // Input command codes
    localparam logic [1:0] CMD_FIRST    = 2'd0;
    localparam logic [1:0] CMD_NEXT     = 2'd1;
    localparam logic [1:0] CMD_PRESENCE = 2'd2;
    localparam logic [1:0] CMD_BIT_PAIR = 2'd3;

    // Result action codes
    localparam logic [1:0] ACT_BUS_RESET = 2'd0;
    localparam logic [1:0] ACT_SEND_CMD  = 2'd1;
    localparam logic [1:0] ACT_WRITE_DIR = 2'd2;
    localparam logic [1:0] ACT_FINISHED  = 2'd3;

    // Search phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_PRESENCE = 3'b010,
        PH_BITS     = 3'b100
    } phase_t;

    // One result item
    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       command_byte;
        logic             direction;
        logic [POS_W-1:0] bit_position;
        logic             found;
        logic             last_device;
        logic [63:0]      rom_code;
        logic [3:0]       family_discrepancy;
        logic             last;
    } result_t;

    // Results produced by one accepted input transaction
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t make_result(
        input logic [1:0]       action,
        input logic [7:0]       command_byte,
        input logic             direction,
        input logic [POS_W-1:0] bit_position,
        input logic             found,
        input logic             last_device,
        input logic [63:0]      rom_code,
        input logic [3:0]       family_discrepancy,
        input logic             last
    );
        result_t r;
        r.action             = action;
        r.command_byte       = command_byte;
        r.direction          = direction;
        r.bit_position       = bit_position;
        r.found              = found;
        r.last_device        = last_device;
        r.rom_code           = rom_code;
        r.family_discrepancy = family_discrepancy;
        r.last               = last;
        return r;
    endfunction

endpackage

// File: rtl/ows_engine.sv
// Search state and combinational decision logic of the 1-Wire search ROM walk.
// Depends on ows_pkg.
module ows_engine
    import ows_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_fire,
    input  logic [1:0] in_command,
    input  logic       in_presence,
    input  logic       in_id_bit,
    input  logic       in_complement_bit,
    output push_t      push
);

    logic [7:0]       search_cmd_reg, search_cmd_next;
    logic [63:0]      rom_reg, rom_next;
    logic [POS_W-1:0] last_disc_reg, last_disc_next;
    logic [3:0]       fam_mark_reg, fam_mark_next;
    logic             no_more_reg, no_more_next;
    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] bit_index_reg, bit_index_next;
    logic [POS_W-1:0] zero_pos_reg, zero_pos_next;

    // Decide the next state and the results of one input transaction
    always_comb
    begin
        logic             no_more_eff;
        logic [3:0]       fam_eff;
        logic [POS_W-1:0] pos;
        logic [5:0]       sel;
        logic             dir;
        logic [63:0]      rom_upd;
        logic [3:0]       fam_upd;
        logic [POS_W-1:0] zero_upd;

        search_cmd_next = cfg_we ? cfg_wdata : search_cmd_reg;
        rom_next        = rom_reg;
        last_disc_next  = last_disc_reg;
        fam_mark_next   = fam_mark_reg;
        no_more_next    = no_more_reg;
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        zero_pos_next   = zero_pos_reg;
        push            = '0;

        no_more_eff = no_more_reg;
        fam_eff     = fam_mark_reg;
        pos         = bit_index_reg;
        sel         = 6'(pos - POS_W'(1));
        dir         = 1'b0;
        rom_upd     = rom_reg;
        fam_upd     = fam_mark_reg;
        zero_upd    = zero_pos_reg;

        if (in_fire)
        begin
            unique case (in_command)
                CMD_FIRST, CMD_NEXT:
                begin
                    // A first search forgets the previous walk
                    if (in_command == CMD_FIRST)
                    begin
                        last_disc_next = '0;
                        no_more_eff    = 1'b0;
                        fam_eff        = '0;
                    end
                    no_more_next   = no_more_eff;
                    fam_mark_next  = fam_eff;
                    bit_index_next = POS_W'(1);
                    zero_pos_next  = '0;
                    push.count     = 2'd1;
                    if (no_more_eff)
                    begin
                        // Last device already reported: finish empty
                        last_disc_next = '0;
                        no_more_next   = 1'b0;
                        fam_mark_next  = '0;
                        phase_next     = PH_IDLE;
                        push.first     = make_result(ACT_FINISHED, 8'd0, 1'b0, '0, 1'b0,
                                                     1'b0, rom_reg, 4'd0, 1'b1);
                    end
                    else
                    begin
                        phase_next = PH_PRESENCE;
                        push.first = make_result(ACT_BUS_RESET, 8'd0, 1'b0, '0, 1'b0,
                                                 1'b0, rom_reg, fam_eff, 1'b1);
                    end
                end

                CMD_PRESENCE:
                begin
                    if (phase_reg == PH_PRESENCE)
                    begin
                        push.count = 2'd1;
                        if (!in_presence)
                        begin
                            // Nobody on the bus
                            last_disc_next = '0;
                            no_more_next   = 1'b0;
                            fam_mark_next  = '0;
                            phase_next     = PH_IDLE;
                            push.first     = make_result(ACT_FINISHED, 8'd0, 1'b0, '0,
                                                         1'b0, 1'b0, rom_reg, 4'd0, 1'b1);
                        end
                        else
                        begin
                            phase_next = PH_BITS;
                            push.first = make_result(ACT_SEND_CMD, search_cmd_reg, 1'b0,
                                                     '0, 1'b0, 1'b0, rom_reg,
                                                     fam_mark_reg, 1'b1);
                        end
                    end
                end

                CMD_BIT_PAIR:
                begin
                    if (phase_reg == PH_BITS && pos >= POS_W'(1)
                        && pos <= POS_W'(ROM_BITS))
                    begin
                        if (in_id_bit && in_complement_bit)
                        begin
                            // Both bits high: devices dropped off
                            push.count     = 2'd1;
                            last_disc_next = '0;
                            no_more_next   = 1'b0;
                            fam_mark_next  = '0;
                            phase_next     = PH_IDLE;
                            push.first     = make_result(ACT_FINISHED, 8'd0, 1'b0, '0,
                                                         1'b0, 1'b0, rom_reg, 4'd0, 1'b1);
                        end
                        else
                        begin
                            // Pick the direction: forced bit, or walk the discrepancy
                            if (in_id_bit != in_complement_bit)
                                dir = in_id_bit;
                            else
                            begin
                                if (pos < last_disc_reg)
                                    dir = rom_reg[sel];
                                else
                                    dir = (pos == last_disc_reg);
                                if (!dir)
                                begin
                                    zero_upd = pos;
                                    if (pos < POS_W'(FAMILY_LIMIT))
                                        fam_upd = 4'(pos);
                                end
                            end
                            rom_upd[sel]   = dir;
                            rom_next       = rom_upd;
                            fam_mark_next  = fam_upd;
                            zero_pos_next  = zero_upd;
                            bit_index_next = pos + POS_W'(1);
                            push.first     = make_result(ACT_WRITE_DIR, 8'd0, dir, pos,
                                                         1'b0, 1'b0, rom_upd, fam_upd,
                                                         pos != POS_W'(ROM_BITS));
                            if (pos != POS_W'(ROM_BITS))
                                push.count = 2'd1;
                            else
                            begin
                                // Final bit: close the walk and report
                                push.count     = 2'd2;
                                phase_next     = PH_IDLE;
                                last_disc_next = zero_upd;
                                if (zero_upd == '0)
                                    no_more_next = 1'b1;
                                if (rom_upd[7:0] == 8'd0)
                                begin
                                    last_disc_next = '0;
                                    no_more_next   = 1'b0;
                                    fam_mark_next  = '0;
                                    push.second    = make_result(ACT_FINISHED, 8'd0, 1'b0,
                                                                 '0, 1'b0, 1'b0, rom_upd,
                                                                 4'd0, 1'b1);
                                end
                                else
                                    push.second = make_result(ACT_FINISHED, 8'd0, 1'b0,
                                                              '0, 1'b1,
                                                              zero_upd == '0, rom_upd,
                                                              fam_upd, 1'b1);
                            end
                        end
                    end
                end

                default:
                begin
                end
            endcase
        end
    end

    // Hold the search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_cmd_reg <= SEARCH_CMD_RESET;
            rom_reg        <= '0;
            last_disc_reg  <= '0;
            fam_mark_reg   <= '0;
            no_more_reg    <= 1'b0;
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= POS_W'(1);
            zero_pos_reg   <= '0;
        end
        else
        begin
            search_cmd_reg <= search_cmd_next;
            rom_reg        <= rom_next;
            last_disc_reg  <= last_disc_next;
            fam_mark_reg   <= fam_mark_next;
            no_more_reg    <= no_more_next;
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            zero_pos_reg   <= zero_pos_next;
        end
    end

endmodule

// File: rtl/ows_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on ows_pkg.
module ows_out_fifo
    import ows_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  push_t              push,
    output result_t            out_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIFO_LW-1:0] level
);

    result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LW-1:0] level_reg, level_next;
    logic               pop;

    assign out_valid = (level_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign level     = level_reg;
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        level_next  = level_reg + FIFO_LW'(push.count) - FIFO_LW'(pop);
    end

    // Store the pushed results
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + FIFO_AW'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// File: rtl/onewire_rom_search_top.sv
// Top level of the 1-Wire search ROM decision engine: stream ports and checks.
// Depends on ows_pkg, ows_engine and ows_out_fifo.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser command, tdata bits
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser action, tdata result, tlast
// cfg       in         cfg_we (no wait)               cfg_wdata search command byte
//
// Each input transaction is decided in the cycle it is accepted; its results are
// registered in the result queue before they reach m_axis. One item per cycle is
// accepted while s_axis_tready is high. The final ROM bit yields two results, so
// a four-entry result queue sits on the output and s_axis_tready falls when fewer
// than two entries are free. Reset sets all state but the queue storage at once.
module onewire_rom_search_top
    import ows_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] presence, [1] id_bit, [2] complement_bit, [7:3] zero
    input  logic [7:0]  s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] command_byte, [8] direction, [15:9] bit_position, [16] found,
    // [17] last_device, [81:18] rom_code, [85:82] family_discrepancy, [87:86] zero
    output logic [87:0] m_axis_tdata,
    // [1:0] action
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    push_t              push;
    result_t            res;
    logic [FIFO_LW-1:0] level;
    logic               in_fire;

    assign s_axis_tready = (level <= FIFO_LW'(FIFO_DEPTH - 2));
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    ows_engine u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_fire           (in_fire),
        .in_command        (s_axis_tuser),
        .in_presence       (s_axis_tdata[0]),
        .in_id_bit         (s_axis_tdata[1]),
        .in_complement_bit (s_axis_tdata[2]),
        .push              (push)
    );

    ows_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_data  (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .level     (level)
    );

    // Pack the result onto the output stream
    assign m_axis_tuser = res.action;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {2'b00, res.family_discrepancy, res.rom_code, res.last_device,
                           res.found, res.bit_position, res.direction, res.command_byte};

    // Queue never overfills
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= FIFO_LW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // Only the final ROM bit yields two results: a direction write then a finish
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (push.first.action == ACT_WRITE_DIR && !push.first.last
                                && push.second.action == ACT_FINISHED && push.second.last))
        else $error("bad result pair");

    // A single result always closes its input transaction
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd1 |-> push.first.last)
        else $error("single result without last");

    // Results appear only for accepted input transactions
    a_push_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> in_fire)
        else $error("result without input transaction");

endmodule
